/* design/lfsb_pkg.sv */
// Package for the leftmost-free stack bank.
// Holds field widths, command and status codes and the controller state type.
// No dependencies.
package lfsb_pkg;

  localparam int CMD_W    = 2;
  localparam int PLATE_W  = 16;
  localparam int SIDX_W   = 6;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 5;
  localparam int CAP_RESET = 16;
  localparam int GRP      = 8;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_RECAP,
    S_IDLE,
    S_DEC,
    S_FILL,
    S_OUT
  } state_t;

endpackage

/* design/lfsb_if.sv */
// Valid/ready channel interfaces for the leftmost-free stack bank.
// Command channel and result channel; field widths come from lfsb_pkg.
interface lfsb_req_if;
  logic                          valid;
  logic                          ready;
  logic [lfsb_pkg::CMD_W-1:0]    cmd;
  logic [lfsb_pkg::PLATE_W-1:0]  plate;
  logic [lfsb_pkg::SIDX_W-1:0]   stack_index;

  modport source (output valid, cmd, plate, stack_index, input ready);
  modport sink (input valid, cmd, plate, stack_index, output ready);
endinterface

interface lfsb_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [lfsb_pkg::PLATE_W-1:0]   popped_value;
  logic [lfsb_pkg::STATUS_W-1:0]  status;
  logic [lfsb_pkg::SIDX_W-1:0]    touched_stack;

  modport source (output valid, popped_value, status, touched_stack, input ready);
  modport sink (input valid, popped_value, status, touched_stack, output ready);
endinterface

/* design/leftmost_free_stack_bank_top.sv */
// Top level of the leftmost-free stack bank: plate and fill-count memories,
// flag vectors with a registered search, and the controlling sequencer.
// Depends on lfsb_pkg and the channel interfaces in lfsb_if.sv.
//
//   channel    dir   handshake        payload
//   req        in    valid/ready      cmd, plate, stack_index
//   rsp        out   valid/ready      popped_value, status, touched_stack
//   cfg        in    cfg_we           cfg_wdata (capacity)
//
// A command that changes a stack passes from its accepting edge to the result register
// through decode with the fill-count read (S_DEC), read-modify-write of the fill
// count with the plate access (S_FILL), then the result load (S_OUT). A command
// that changes nothing skips S_FILL. No new command is taken until the result is
// loaded and the sequencer is back in S_IDLE; the memory reads are registered.
// After reset a clearing pass zeroes the fill counts; after a capacity write a
// recap pass rebuilds the full flags from the fill counts.
// req.ready stays low during both passes and while a command is in flight.
// A result waiting on rsp holds the command in S_OUT, its final state, only.
module leftmost_free_stack_bank_top #(
  parameter int NUM_STACKS  = 64,
  parameter int STACK_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  lfsb_req_if.sink                   req,
  lfsb_rsp_if.source                 rsp,
  input  logic                       cfg_we,
  input  logic [lfsb_pkg::CAP_W-1:0] cfg_wdata
);
  import lfsb_pkg::*;

  localparam int SW  = $clog2(NUM_STACKS);
  localparam int NG  = (NUM_STACKS + GRP - 1) / GRP;
  localparam int PN  = NG * GRP;
  localparam int PSW = $clog2(PN);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int LW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PD  = NUM_STACKS * STACK_DEPTH;
  localparam int PW  = $clog2(PD);
  localparam int KW  = $clog2(NUM_STACKS + 2);
  localparam logic [CW-1:0] CAP_RST =
    CW'((STACK_DEPTH < CAP_RESET) ? STACK_DEPTH : CAP_RESET);

  logic [PLATE_W-1:0] plate_mem [PD];
  logic [CW-1:0]      fill_mem  [NUM_STACKS];

  state_t state, state_next;
  logic [KW-1:0]       cnt;
  logic                recap_pend;
  logic [CW-1:0]       cap_eff;
  logic [NUM_STACKS-1:0] full_vec;
  logic [NUM_STACKS-1:0] ne_vec;
  logic [PN-1:0]       full_pad;
  logic [PN-1:0]       ne_pad;
  logic [NG-1:0]       zf;
  logic [2:0]          zp [NG];
  logic [NG-1:0]       of;
  logic [2:0]          op [NG];
  logic [NG-1:0]       zf_c;
  logic [2:0]          zp_c [NG];
  logic [NG-1:0]       of_c;
  logic [2:0]          op_c [NG];

  logic [CMD_W-1:0]    cur_cmd;
  logic [PLATE_W-1:0]  cur_plate;
  logic [SIDX_W-1:0]   cur_idx;
  logic [SW-1:0]       sel;
  logic [PW-1:0]       base_addr;
  logic                act;
  logic [STATUS_W-1:0] res_status;

  logic [CW-1:0]       fill_rd;
  logic [PLATE_W-1:0]  plate_rd;
  logic                sweep_vld;
  logic [SW-1:0]       sweep_prev;

  logic                t_found;
  logic [PSW-1:0]      t_idx;
  logic                l_found;
  logic [PSW-1:0]      l_idx;
  logic [SW+SIDX_W-1:0] idx_ext;
  logic [SW-1:0]       idx_s;
  logic                dec_act;
  logic [SW-1:0]       dec_sel;
  logic [STATUS_W-1:0] dec_status;

  logic                fill_re;
  logic [SW-1:0]       fill_ra;
  logic                fill_we;
  logic [SW-1:0]       fill_wa;
  logic [CW-1:0]       fill_wd;
  logic [CW-1:0]       fill_new;
  logic [LW-1:0]       slot;
  logic                plate_we;
  logic                plate_re;
  logic [PW-1:0]       plate_addr;
  logic                out_load;
  logic                cmd_acc;

  // Padding stacks count as full and empty so the searches never pick them.
  always_comb begin
    full_pad = '1;
    full_pad[NUM_STACKS-1:0] = full_vec;
    ne_pad = '0;
    ne_pad[NUM_STACKS-1:0] = ne_vec;
  end

  // First search level: leftmost non-full and rightmost non-empty per group.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      zf_c[g] = 1'b0;
      zp_c[g] = '0;
      of_c[g] = 1'b0;
      op_c[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (!full_pad[g*GRP + j]) begin
          zf_c[g] = 1'b1;
          zp_c[g] = 3'(j);
        end
      end
      for (int j = 0; j < GRP; j++) begin
        if (ne_pad[g*GRP + j]) begin
          of_c[g] = 1'b1;
          op_c[g] = 3'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    zf <= zf_c;
    zp <= zp_c;
    of <= of_c;
    op <= op_c;
  end

  // Second search level and command decode.
  always_comb begin
    t_found = 1'b0;
    t_idx   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (zf[g]) begin
        t_found = 1'b1;
        t_idx   = PSW'(g * GRP) | PSW'(zp[g]);
      end
    end
    l_found = 1'b0;
    l_idx   = '0;
    for (int g = 0; g < NG; g++) begin
      if (of[g]) begin
        l_found = 1'b1;
        l_idx   = PSW'(g * GRP) | PSW'(op[g]);
      end
    end
    idx_ext = (SW + SIDX_W)'(cur_idx);
    idx_s   = idx_ext[SW-1:0];

    dec_act    = 1'b0;
    dec_sel    = '0;
    dec_status = ST_DONE;
    case (cur_cmd)
      CMD_PUSH: begin
        if (t_found) begin
          dec_act = 1'b1;
          dec_sel = t_idx[SW-1:0];
        end else begin
          dec_status = ST_FULL;
        end
      end
      CMD_POP: begin
        if (l_found) begin
          dec_act = 1'b1;
          dec_sel = l_idx[SW-1:0];
        end else begin
          dec_status = ST_EMPTY;
        end
      end
      CMD_POP_AT: begin
        if ((int'(cur_idx) < NUM_STACKS) && ne_vec[idx_s]) begin
          dec_act = 1'b1;
          dec_sel = idx_s;
        end else begin
          dec_status = ST_EMPTY;
        end
      end
      default: begin
        dec_status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    if (cur_cmd == CMD_PUSH) begin
      fill_new = fill_rd + CW'(1);
      slot     = fill_rd[LW-1:0];
    end else begin
      fill_new = fill_rd - CW'(1);
      slot     = fill_new[LW-1:0];
    end
    plate_addr = base_addr + PW'(slot);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (int'(cnt) == NUM_STACKS + 1) begin
          state_next = S_IDLE;
        end
      end
      S_RECAP: begin
        if (int'(cnt) == NUM_STACKS + 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (recap_pend) begin
          state_next = S_RECAP;
        end else if (cmd_acc) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = dec_act ? S_FILL : S_OUT;
      end
      S_FILL: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    fill_re   = 1'b0;
    fill_ra   = '0;
    fill_we   = 1'b0;
    fill_wa   = '0;
    fill_wd   = '0;
    plate_we  = 1'b0;
    plate_re  = 1'b0;
    out_load  = 1'b0;
    case (state)
      S_CLEAR: begin
        if (int'(cnt) < NUM_STACKS) begin
          fill_we = 1'b1;
          fill_wa = cnt[SW-1:0];
        end
      end
      S_RECAP: begin
        if (int'(cnt) < NUM_STACKS) begin
          fill_re = 1'b1;
          fill_ra = cnt[SW-1:0];
        end
      end
      S_IDLE: begin
        req.ready = !recap_pend && !cfg_we;
      end
      S_DEC: begin
        fill_re = dec_act;
        fill_ra = dec_sel;
      end
      S_FILL: begin
        fill_we  = 1'b1;
        fill_wa  = sel;
        fill_wd  = fill_new;
        plate_we = (cur_cmd == CMD_PUSH);
        plate_re = (cur_cmd != CMD_PUSH);
      end
      S_OUT: begin
        out_load = !rsp.valid || rsp.ready;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign cmd_acc = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    if (fill_re) begin
      fill_rd <= fill_mem[fill_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (plate_we) begin
      plate_mem[plate_addr] <= cur_plate;
    end
    if (plate_re) begin
      plate_rd <= plate_mem[plate_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      recap_pend <= 1'b0;
      cap_eff    <= CAP_RST;
      full_vec   <= '0;
      ne_vec     <= '0;
      sweep_vld  <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else if (state == S_CLEAR || state == S_RECAP) begin
        cnt <= cnt + KW'(1);
      end

      if (cfg_we) begin
        recap_pend <= 1'b1;
        if (cfg_wdata == '0) begin
          cap_eff <= CW'(1);
        end else if (int'(cfg_wdata) > STACK_DEPTH) begin
          cap_eff <= CW'(STACK_DEPTH);
        end else begin
          cap_eff <= CW'(cfg_wdata);
        end
      end else if (state == S_IDLE && recap_pend) begin
        recap_pend <= 1'b0;
      end

      sweep_vld  <= (state == S_RECAP) && fill_re;
      sweep_prev <= fill_ra;
      if (sweep_vld) begin
        full_vec[sweep_prev] <= (fill_rd >= cap_eff);
      end

      if (state == S_FILL) begin
        full_vec[sel] <= (fill_new >= cap_eff);
        ne_vec[sel]   <= (fill_new != '0);
      end

      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      cur_cmd   <= req.cmd;
      cur_plate <= req.plate;
      cur_idx   <= req.stack_index;
    end
    if (state == S_DEC) begin
      act        <= dec_act;
      sel        <= dec_sel;
      res_status <= dec_status;
      base_addr  <= PW'(dec_sel * STACK_DEPTH);
    end
    if (out_load) begin
      rsp.status        <= res_status;
      rsp.touched_stack <= act ? SIDX_W'(sel) : '0;
      rsp.popped_value  <= (act && cur_cmd != CMD_PUSH) ? plate_rd : '0;
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> state == S_DEC)
    else $error("accepted command did not enter decode");

  a_full_implies_nonempty: assert property (@(posedge clk) disable iff (rst)
    (full_vec & ~ne_vec) == '0)
    else $error("stack flagged full while flagged empty");

  a_pop_has_plate: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && cur_cmd != CMD_PUSH) |-> fill_rd != '0)
    else $error("pop reached an empty fill count");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_OUT)
    else $error("result beat raised outside the result state");

endmodule
